>>> sv/hodm_pkg.sv
package hodm_pkg;

  localparam logic [1:0] CMD_DICT  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] FOLD_OFFSET  = 8'd32;
  localparam logic [5:0] POS_MAX      = 6'd63;

  typedef struct packed {
    logic [5:0] len;
    logic       too_long;
  } job_t;

  function automatic logic [7:0] fold_char(input logic [7:0] raw);
    fold_char = (raw < CHAR_LOWER_A) ? raw + FOLD_OFFSET : raw;
  endfunction

endpackage

>>> sv/hamming_one_dictionary_match.sv
// Characters are taken one per cycle while busy is low. A query word end hands the
// query to the compare engine and raises busy from the next cycle. The engine walks
// the stored words one memory read per cycle: for each it reads the stored length,
// and a word of equal length is compared with the query character by character.
// The walk stops at the first word that differs in at most one character. The result
// appears with out_valid for one cycle, in which busy is already low, and cannot be
// stalled.
module hamming_one_dictionary_match import hodm_pkg::*; #(
  parameter int MAX_WORDS = 256,
  parameter int MAX_LEN   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [7:0] in_char_code,
  input  logic       in_word_end,
  output logic       out_valid,
  output logic       out_found,
  output logic       out_length_error,
  output logic       out_store_full
);

  localparam int WAW = $clog2(MAX_WORDS + 1);
  localparam int WW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int PW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic           take;
  logic           st_we, len_we, q_we, job_push, job_pop, overflow;
  logic [WAW-1:0] st_word, word_count;
  logic [PW-1:0]  st_pos, rd_pos;
  logic [WW-1:0]  rd_word;
  logic [7:0]     st_char, st_rdata, q_rdata;
  logic [5:0]     len_rdata;
  job_t           job_in, job_r;
  logic           job_valid_r;

  assign busy = job_valid_r;
  assign take = start && !busy;

  hodm_front #(.MAX_WORDS(MAX_WORDS), .MAX_LEN(MAX_LEN)) u_front (
    .clk, .rst_n, .in_take(take), .in_command, .in_char_code, .in_word_end,
    .st_we, .st_word, .st_pos, .st_char, .len_we, .q_we, .job_push,
    .job(job_in), .word_count, .overflow
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (take && job_push) begin
      job_valid_r <= 1'b1;
    end else if (job_pop) begin
      job_valid_r <= 1'b0;
    end
    if (take && job_push) begin
      job_r <= job_in;
    end
  end

  hodm_ram #(.WIDTH(8), .DEPTH((1 << WW) * (1 << PW))) u_store (
    .clk, .we(st_we), .waddr({WW'(st_word), st_pos}), .wdata(st_char),
    .raddr({rd_word, rd_pos}), .rdata(st_rdata)
  );

  hodm_ram #(.WIDTH(6), .DEPTH(MAX_WORDS)) u_len (
    .clk, .we(len_we), .waddr(WW'(st_word)), .wdata(6'(st_pos) + 6'd1),
    .raddr(rd_word), .rdata(len_rdata)
  );

  hodm_ram #(.WIDTH(8), .DEPTH(1 << PW)) u_query (
    .clk, .we(q_we), .waddr(st_pos), .wdata(st_char),
    .raddr(rd_pos), .rdata(q_rdata)
  );

  hodm_back #(.MAX_WORDS(MAX_WORDS), .MAX_LEN(MAX_LEN)) u_back (
    .clk, .rst_n, .job_valid(job_valid_r), .job(job_r), .word_count, .overflow,
    .job_pop, .rd_word, .rd_pos, .st_rdata, .len_rdata, .q_rdata,
    .out_valid, .out_found, .out_length_error, .out_store_full
  );

endmodule

>>> sv/hodm_ram.sv
module hodm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/hodm_front.sv
module hodm_front import hodm_pkg::*; #(
  parameter int MAX_WORDS = 256,
  parameter int MAX_LEN   = 32,
  localparam int WAW = $clog2(MAX_WORDS + 1),
  localparam int PW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_take,
  input  logic [1:0]           in_command,
  input  logic [7:0]           in_char_code,
  input  logic                 in_word_end,
  output logic                 st_we,
  output logic [WAW-1:0]       st_word,
  output logic [PW-1:0]        st_pos,
  output logic [7:0]           st_char,
  output logic                 len_we,
  output logic                 q_we,
  output logic                 job_push,
  output job_t                 job,
  output logic [WAW-1:0]       word_count,
  output logic                 overflow
);

  logic [WAW-1:0] count_r, count_nxt;
  logic [5:0]     pos_r, pos_nxt;
  logic           ovf_r, ovf_nxt;
  logic           is_char;
  logic           too_long;
  logic           room;
  logic [7:0]     c;

  assign is_char  = in_take && (in_command == CMD_DICT || in_command == CMD_QUERY);
  assign too_long = pos_r >= 6'(MAX_LEN);
  assign room     = count_r < WAW'(MAX_WORDS);
  assign c        = fold_char(in_char_code);

  assign st_we    = is_char && !too_long && room;
  assign q_we     = is_char && !too_long;
  assign st_word  = count_r;
  assign st_pos   = PW'(pos_r);
  assign st_char  = c;
  assign len_we   = is_char && in_word_end && in_command == CMD_DICT && !too_long && room;
  assign job_push = is_char && in_word_end && in_command == CMD_QUERY;
  assign job.len       = pos_r + 6'd1;
  assign job.too_long  = too_long;
  assign word_count = count_r;
  assign overflow   = ovf_r;

  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    ovf_nxt   = ovf_r;
    if (in_take && in_command == CMD_CLEAR) begin
      count_nxt = '0;
      pos_nxt   = '0;
      ovf_nxt   = 1'b0;
    end else if (is_char) begin
      if (pos_r < POS_MAX) begin
        pos_nxt = pos_r + 6'd1;
      end
      if (in_word_end) begin
        pos_nxt = '0;
        if (in_command == CMD_DICT) begin
          if (too_long || !room) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + WAW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pos_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

>>> sv/hodm_back.sv
module hodm_back import hodm_pkg::*; #(
  parameter int MAX_WORDS = 256,
  parameter int MAX_LEN   = 32,
  localparam int WAW = $clog2(MAX_WORDS + 1),
  localparam int WW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
  localparam int PW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  job_t           job,
  input  logic [WAW-1:0] word_count,
  input  logic           overflow,
  output logic           job_pop,
  output logic [WW-1:0]  rd_word,
  output logic [PW-1:0]  rd_pos,
  input  logic [7:0]     st_rdata,
  input  logic [5:0]     len_rdata,
  input  logic [7:0]     q_rdata,
  output logic           out_valid,
  output logic           out_found,
  output logic           out_length_error,
  output logic           out_store_full
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LEN  = 4'b0010,
    S_CMP  = 4'b0100,
    S_NEXT = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;
  logic [WAW-1:0] w_r, w_nxt;
  logic [5:0]     j_r, j_nxt;
  logic [1:0]     diff_r, diff_nxt;
  logic           rd_pend_r, rd_pend_nxt;
  logic           found_r, found_nxt;
  logic           valid_r, valid_nxt;
  logic           done;

  assign rd_word = WW'(w_r);
  assign rd_pos  = PW'(j_r);
  assign out_valid        = valid_r;
  assign out_found        = found_r;
  assign out_length_error = valid_r && job.too_long;
  assign out_store_full   = overflow;

  always_comb begin
    state_nxt   = state_r;
    w_nxt       = w_r;
    j_nxt       = j_r;
    diff_nxt    = diff_r;
    rd_pend_nxt = 1'b0;
    found_nxt   = found_r;
    valid_nxt   = 1'b0;
    job_pop     = 1'b0;
    done        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid && !valid_r) begin
          w_nxt     = '0;
          found_nxt = 1'b0;
          if (job.too_long || word_count == '0) begin
            done = 1'b1;
          end else begin
            state_nxt   = S_LEN;
            rd_pend_nxt = 1'b1;
          end
        end
      end
      S_LEN: begin
        if (!rd_pend_r) begin
          if (len_rdata == job.len) begin
            state_nxt   = S_CMP;
            j_nxt       = 6'd0;
            diff_nxt    = 2'd0;
            rd_pend_nxt = 1'b1;
          end else begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_CMP: begin
        if (rd_pend_r) begin
          j_nxt = j_r + 6'd1;
        end else begin
          if (st_rdata != q_rdata && diff_r != 2'd2) begin
            diff_nxt = diff_r + 2'd1;
          end
          if (j_r == job.len) begin
            state_nxt = S_NEXT;
            if (diff_r == 2'd0 || (diff_r == 2'd1 && st_rdata == q_rdata)) begin
              found_nxt = 1'b1;
              done      = 1'b1;
            end
          end else begin
            j_nxt       = j_r + 6'd1;
            rd_pend_nxt = 1'b0;
          end
        end
      end
      S_NEXT: begin
        if (w_r + WAW'(1) >= word_count) begin
          done = 1'b1;
        end else begin
          w_nxt       = w_r + WAW'(1);
          state_nxt   = S_LEN;
          rd_pend_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (done) begin
      state_nxt = S_IDLE;
      valid_nxt = 1'b1;
      job_pop   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      valid_r   <= valid_nxt;
    end
    w_r     <= w_nxt;
    j_r     <= j_nxt;
    diff_r  <= diff_nxt;
    found_r <= found_nxt;
  end

endmodule
